FILE: hdl/assert_macros.svh
// Assertion helpers shared by the downscaler modules.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge once reset is released.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the condition holds, the consequence must hold in the same cycle.
`define ASSERT_IMPLIES(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

`endif

FILE: hdl/rbd_pkg.sv
// ----------------------------------------------------------------------------
// rbd_pkg
// Types and constants shared by the 2x2 box downscaler modules.
// ----------------------------------------------------------------------------
package rbd_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ADDR_W     = $clog2(LINE_DEPTH);
    localparam int WIDTH_W    = 12;
    localparam int EW_A       = ($clog2(MAX_WIDTH + 1) > WIDTH_W) ? $clog2(MAX_WIDTH + 1)
                                                                  : WIDTH_W;
    // Width used for every comparison against the line width.
    localparam int EW_W       = (EW_A > COL_W + 1) ? EW_A : COL_W + 1;
    localparam int PIX_W      = 8;
    localparam int SUM_W      = PIX_W + 1;
    localparam int TOT_W      = PIX_W + 2;
    localparam int LINE_W     = 3 * SUM_W;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W     = $clog2(QUEUE_DEPTH);

    localparam logic [WIDTH_W-1:0] LINE_WIDTH_RESET = WIDTH_W'(640);

    typedef struct packed {
        logic             frame_start;
        logic [PIX_W-1:0] chan0;
        logic [PIX_W-1:0] chan1;
        logic [PIX_W-1:0] chan2;
    } pix_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] out0;
        logic [PIX_W-1:0] out1;
        logic [PIX_W-1:0] out2;
        logic             row_end;
    } pix_out_t;

    typedef enum logic [0:0] {
        CMD_STORE = 1'b0,
        CMD_EMIT  = 1'b1
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t          op;
        logic [ADDR_W-1:0] addr;
        logic [SUM_W-1:0] sum0;
        logic [SUM_W-1:0] sum1;
        logic [SUM_W-1:0] sum2;
        logic             row_end;
    } cmd_t;

    // Handshake between the command queue and the back end.
    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

endpackage

FILE: hdl/rgb_box_downscale_2x2.sv
// ----------------------------------------------------------------------------
// rgb_box_downscale_2x2
// 2x2 box-filter downscaler for a raster stream of three-channel pixels.
// ----------------------------------------------------------------------------
//  Channel  Signals                          Direction  Transaction
//  pix      pix_valid, pix_ready, pix        in         one input pixel
//  res      res_valid, res_ready, res        out        one averaged pixel
//  cfg      cfg_valid, cfg_ready, cfg_data   in         line width write
//
// One pixel is taken per clock while the four-entry command queue has room.
// After its queue entry is popped, a result is read from the line store into a register
// and then added into the output register, which waits while the output is stalled.
// The line store is a single-port memory of MAX_WIDTH/2 entries; its contents
// are undefined after reset and are written by each even row before use.
// Reset clears position and all valid flags and sets the line width to 640.
// A stalled output fills the queue, after which pix_ready drops.
// ----------------------------------------------------------------------------
module rgb_box_downscale_2x2
    import rbd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pix_valid,
    output logic               pix_ready,
    input  pix_in_t            pix,
    output logic               res_valid,
    input  logic               res_ready,
    output pix_out_t           res,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [WIDTH_W-1:0] cfg_data
);

    logic          accept;
    logic          push;
    cmd_t          push_cmd;
    logic          pop;
    cmd_t          head;
    queue_status_t status;

    assign pix_ready = !status.full;
    assign accept    = pix_valid && pix_ready;
    assign cfg_ready = 1'b1;

    rbd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .pix       (pix),
        .push      (push),
        .cmd       (push_cmd)
    );

    rbd_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .status   (status)
    );

    rbd_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .status    (status),
        .pop       (pop),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

endmodule

FILE: hdl/rbd_front.sv
// ----------------------------------------------------------------------------
// rbd_front
// Tracks column and row parity, forms horizontal pair sums and classifies
// each pixel as a line-store write, an emit command or nothing.
// ----------------------------------------------------------------------------
module rbd_front
    import rbd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic [WIDTH_W-1:0] cfg_data,
    input  logic               accept,
    input  pix_in_t            pix,
    output logic               push,
    output cmd_t               cmd
);

    logic [WIDTH_W-1:0] line_width_reg;
    logic [COL_W-1:0]   column_reg;
    logic [COL_W-1:0]   column_next;
    logic               row_odd_reg;
    logic               row_odd_next;
    logic [PIX_W-1:0]   left0_reg;
    logic [PIX_W-1:0]   left1_reg;
    logic [PIX_W-1:0]   left2_reg;

    logic [EW_W-1:0]    lw_ext;
    logic [EW_W-1:0]    width_eff;
    logic [EW_W-1:0]    pairs;
    logic [COL_W-1:0]   col_cur;
    logic               odd_cur;
    logic [EW_W-1:0]    pair_idx;
    logic [EW_W-1:0]    col_inc;
    logic               in_range;
    logic               wrap;

    always_comb
    begin
        lw_ext = EW_W'(line_width_reg);
        if (lw_ext < EW_W'(2))
        begin
            width_eff = EW_W'(2);
        end
        else if (lw_ext > EW_W'(MAX_WIDTH))
        begin
            width_eff = EW_W'(MAX_WIDTH);
        end
        else
        begin
            width_eff = lw_ext;
        end
        pairs = width_eff >> 1;

        // A frame start clears position before this pixel is classified.
        col_cur  = pix.frame_start ? '0 : column_reg;
        odd_cur  = pix.frame_start ? 1'b0 : row_odd_reg;
        pair_idx = EW_W'(col_cur >> 1);
        in_range = pair_idx < pairs;
        col_inc  = EW_W'(col_cur) + EW_W'(1);
        wrap     = col_inc >= width_eff;

        column_next  = wrap ? '0 : col_inc[COL_W-1:0];
        row_odd_next = wrap ? ~odd_cur : odd_cur;

        push        = accept && col_cur[0] && in_range;
        cmd.op      = odd_cur ? CMD_EMIT : CMD_STORE;
        cmd.addr    = pair_idx[ADDR_W-1:0];
        cmd.sum0    = SUM_W'(left0_reg) + SUM_W'(pix.chan0);
        cmd.sum1    = SUM_W'(left1_reg) + SUM_W'(pix.chan1);
        cmd.sum2    = SUM_W'(left2_reg) + SUM_W'(pix.chan2);
        cmd.row_end = pair_idx == (pairs - EW_W'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= LINE_WIDTH_RESET;
            column_reg     <= '0;
            row_odd_reg    <= 1'b0;
            left0_reg      <= '0;
            left1_reg      <= '0;
            left2_reg      <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                line_width_reg <= cfg_data;
            end
            if (accept)
            begin
                column_reg  <= column_next;
                row_odd_reg <= row_odd_next;
                if (!col_cur[0])
                begin
                    left0_reg <= pix.chan0;
                    left1_reg <= pix.chan1;
                    left2_reg <= pix.chan2;
                end
            end
        end
    end

endmodule

FILE: hdl/rbd_queue.sv
// ----------------------------------------------------------------------------
// rbd_queue
// Short command FIFO that decouples pixel intake from line-store work.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rbd_queue
    import rbd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cmd_t          push_cmd,
    input  logic          pop,
    output cmd_t          head,
    output queue_status_t status
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;

    always_comb
    begin
        status.empty = count_reg == '0;
        status.full  = count_reg == (QPTR_W + 1)'(QUEUE_DEPTH);
        head         = entry_reg[rd_ptr_reg];
        count_next   = count_reg + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `ASSERT_ALWAYS(a_no_overflow, !(push && status.full), "command pushed into a full queue")
    `ASSERT_ALWAYS(a_no_underflow, !(pop && status.empty), "command popped from an empty queue")

endmodule

FILE: hdl/rbd_back.sv
// ----------------------------------------------------------------------------
// rbd_back
// Executes queued commands against the line store and produces the
// averaged output pixels through a registered output stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rbd_back
    import rbd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  cmd_t          head,
    input  queue_status_t status,
    output logic          pop,
    output logic          res_valid,
    input  logic          res_ready,
    output pix_out_t      res
);

    logic [LINE_W-1:0] line_mem [LINE_DEPTH];
    logic [LINE_W-1:0] rd_data_reg;
    cmd_t              b_cmd_reg;
    logic              b_valid_reg;
    logic              b_valid_next;
    pix_out_t          res_reg;
    logic              res_valid_reg;
    logic              res_valid_next;

    logic              out_load;
    logic              b_free;
    logic              do_write;
    logic              do_read;
    logic [TOT_W-1:0]  tot0;
    logic [TOT_W-1:0]  tot1;
    logic [TOT_W-1:0]  tot2;
    pix_out_t          res_calc;

    always_comb
    begin
        out_load = b_valid_reg && (!res_valid_reg || res_ready);
        b_free   = !b_valid_reg || out_load;
        // Stores never wait on the output side; reads need the read stage free.
        pop      = !status.empty && ((head.op == CMD_STORE) || b_free);
        do_write = pop && (head.op == CMD_STORE);
        do_read  = pop && (head.op == CMD_EMIT);

        b_valid_next   = do_read || (b_valid_reg && !out_load);
        res_valid_next = out_load || (res_valid_reg && !res_ready);

        tot0 = TOT_W'(b_cmd_reg.sum0) + TOT_W'(rd_data_reg[SUM_W-1:0]);
        tot1 = TOT_W'(b_cmd_reg.sum1) + TOT_W'(rd_data_reg[2*SUM_W-1:SUM_W]);
        tot2 = TOT_W'(b_cmd_reg.sum2) + TOT_W'(rd_data_reg[3*SUM_W-1:2*SUM_W]);

        // Output channels are permuted relative to the input channels.
        res_calc.out0    = tot2[TOT_W-1:2];
        res_calc.out1    = tot0[TOT_W-1:2];
        res_calc.out2    = tot1[TOT_W-1:2];
        res_calc.row_end = b_cmd_reg.row_end;

        res_valid = res_valid_reg;
        res       = res_reg;
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            line_mem[head.addr] <= {head.sum2, head.sum1, head.sum0};
        end
        if (do_read)
        begin
            rd_data_reg <= line_mem[head.addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_read)
        begin
            b_cmd_reg <= head;
        end
        if (out_load)
        begin
            res_reg <= res_calc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg   <= b_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    `ASSERT_IMPLIES(a_read_slot_free, do_read && b_valid_reg, out_load, "read over a held stage")
    `ASSERT_IMPLIES(a_output_held, res_valid_reg && !res_ready, !out_load, "output overwritten")

endmodule

FILE: test/rgb_box_downscale_2x2_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_box_downscale_2x2_tb
// Self-checking bench for the 2x2 box-filter downscaler.
// Pixels are streamed in raster order under random source gaps and sink stalls.
// A behavioral copy of the downscaler predicts every averaged pixel, and each
// result transaction is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module rgb_box_downscale_2x2_tb;
    import rbd_pkg::*;

    localparam int unsigned SETTLE_CYCLES = 12;
    localparam int unsigned STALL_LIMIT   = 2000;
    localparam int unsigned RANDOM_PIXELS = 600;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 pix_valid = 1'b0;
    logic                 pix_ready;
    pix_in_t              pix_item = '0;
    logic                 res_valid;
    logic                 res_ready = 1'b0;
    pix_out_t             res_item;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [WIDTH_W-1:0]   cfg_data = '0;

    // Behavioral state of the downscaler.
    logic [WIDTH_W-1:0]   width_reg = LINE_WIDTH_RESET;
    logic [COL_W-1:0]     col_pos = '0;
    bit                   row_is_odd = 1'b0;
    logic [PIX_W-1:0]     left_c0 = '0;
    logic [PIX_W-1:0]     left_c1 = '0;
    logic [PIX_W-1:0]     left_c2 = '0;
    logic [SUM_W-1:0]     line_sum0 [LINE_DEPTH];
    logic [SUM_W-1:0]     line_sum1 [LINE_DEPTH];
    logic [SUM_W-1:0]     line_sum2 [LINE_DEPTH];
    bit                   line_written [LINE_DEPTH];

    pix_out_t             expected_means[$];
    int unsigned          mismatches = 0;
    int unsigned          pixels_sent = 0;
    int unsigned          quiet_cycles = 0;

    int unsigned          src_gap_pct = 15;
    int unsigned          sink_stall_pct = 15;
    int unsigned          hold_request = 0;
    int unsigned          hold_left = 0;
    int unsigned          stall_left = 0;

    rgb_box_downscale_2x2 dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned eff_width();
        int unsigned w;
        w = width_reg;
        if (w < 2)
        begin
            w = 2;
        end
        if (w > MAX_WIDTH)
        begin
            w = MAX_WIDTH;
        end
        return w;
    endfunction

    // Advances the behavioral copy by one accepted pixel and queues the
    // averaged pixel when the pixel closes a 2x2 block.
    task automatic accumulate_pixel(input pix_in_t p);
        int unsigned      w;
        int unsigned      pairs;
        int unsigned      idx;
        logic [SUM_W-1:0] s0, s1, s2;
        logic [TOT_W-1:0] t0, t1, t2;
        pix_out_t         mean;
        w = eff_width();
        pairs = w >> 1;
        if (p.frame_start)
        begin
            col_pos = '0;
            row_is_odd = 1'b0;
        end
        if (!col_pos[0])
        begin
            left_c0 = p.chan0;
            left_c1 = p.chan1;
            left_c2 = p.chan2;
        end
        else if ((col_pos >> 1) < pairs)
        begin
            idx = (col_pos >> 1) & (LINE_DEPTH - 1);
            s0 = SUM_W'(left_c0) + SUM_W'(p.chan0);
            s1 = SUM_W'(left_c1) + SUM_W'(p.chan1);
            s2 = SUM_W'(left_c2) + SUM_W'(p.chan2);
            if (!row_is_odd)
            begin
                line_sum0[idx] = s0;
                line_sum1[idx] = s1;
                line_sum2[idx] = s2;
                line_written[idx] = 1'b1;
            end
            else
            begin
                t0 = TOT_W'(s0) + TOT_W'(line_sum0[idx]);
                t1 = TOT_W'(s1) + TOT_W'(line_sum1[idx]);
                t2 = TOT_W'(s2) + TOT_W'(line_sum2[idx]);
                mean.out0 = t2[TOT_W-1:2];
                mean.out1 = t0[TOT_W-1:2];
                mean.out2 = t1[TOT_W-1:2];
                mean.row_end = ((col_pos >> 1) == pairs - 1);
                expected_means.push_back(mean);
            end
        end
        if (col_pos + 1 >= w)
        begin
            col_pos = '0;
            row_is_odd = ~row_is_odd;
        end
        else
        begin
            col_pos = col_pos + 1'b1;
        end
    endtask

    // An odd row must never read a line-store entry that no even row has
    // written yet; such a pixel starts a new frame instead.
    function automatic bit needs_fresh_frame(input pix_in_t p);
        int unsigned idx;
        if (p.frame_start || !row_is_odd || !col_pos[0])
        begin
            return 1'b0;
        end
        if ((col_pos >> 1) >= (eff_width() >> 1))
        begin
            return 1'b0;
        end
        idx = (col_pos >> 1) & (LINE_DEPTH - 1);
        return !line_written[idx];
    endfunction

    function automatic logic [PIX_W-1:0] random_sample();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic pix_in_t random_pixel();
        pix_in_t p;
        p.frame_start = 1'b0;
        p.chan0 = random_sample();
        p.chan1 = random_sample();
        p.chan2 = random_sample();
        return p;
    endfunction

    task automatic send_pixel(input pix_in_t p);
        if (needs_fresh_frame(p))
        begin
            p.frame_start = 1'b1;
        end
        if ($urandom_range(0, 99) < src_gap_pct)
        begin
            pix_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix_item <= p;
        do @(posedge clk); while (!pix_ready);
        accumulate_pixel(p);
        pixels_sent++;
    endtask

    // Sends whole rows at the current width. A nonzero noise rate (per mille)
    // scatters stray frame starts and may cut the frame short.
    task automatic send_rows(input int unsigned rows, input bit fresh,
                             input int unsigned noise);
        int unsigned total;
        pix_in_t     p;
        total = rows * eff_width();
        for (int unsigned n = 0; n < total; n++)
        begin
            if (n != 0 && $urandom_range(0, 999) < noise)
            begin
                break;
            end
            p = random_pixel();
            p.frame_start = (fresh && n == 0) || ($urandom_range(0, 999) < noise);
            send_pixel(p);
        end
    endtask

    // Waits until every predicted pixel has come out and the pipeline has
    // had time to finish any store-only work.
    task automatic drain();
        pix_valid <= 1'b0;
        do @(posedge clk); while (expected_means.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_width(input logic [WIDTH_W-1:0] w);
        cfg_valid <= 1'b1;
        cfg_data <= w;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        width_reg = w;
    endtask

    // Result side: checks each transaction and paces res_ready.
    always @(posedge clk)
    begin : result_side
        pix_out_t want;
        if (rst_n)
        begin
            if (res_valid && res_ready)
            begin
                if (expected_means.size() == 0)
                begin
                    $error("unexpected result: out0 %0d out1 %0d out2 %0d row_end %0d",
                           res_item.out0, res_item.out1, res_item.out2, res_item.row_end);
                    mismatches++;
                end
                else
                begin
                    want = expected_means.pop_front();
                    if (res_item.out0 !== want.out0)
                    begin
                        $error("out0: expected %0d, got %0d", want.out0, res_item.out0);
                        mismatches++;
                    end
                    if (res_item.out1 !== want.out1)
                    begin
                        $error("out1: expected %0d, got %0d", want.out1, res_item.out1);
                        mismatches++;
                    end
                    if (res_item.out2 !== want.out2)
                    begin
                        $error("out2: expected %0d, got %0d", want.out2, res_item.out2);
                        mismatches++;
                    end
                    if (res_item.row_end !== want.row_end)
                    begin
                        $error("row_end: expected %0d, got %0d", want.row_end,
                               res_item.row_end);
                        mismatches++;
                    end
                end
            end
            if (hold_request != 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                res_ready <= 1'b0;
            end
            else if (stall_left != 0)
            begin
                stall_left--;
                res_ready <= 1'b0;
            end
            else if ($urandom_range(0, 99) < sink_stall_pct)
            begin
                stall_left = $urandom_range(1, 19) - 1;
                res_ready <= 1'b0;
            end
            else
            begin
                res_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (pix_valid && pix_ready) || (res_valid && res_ready) ||
            (cfg_valid && cfg_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // The first pixels of a frame at the width that reset leaves behind; the
    // row is far from its end, so nothing comes out yet.
    task automatic test_reset_width();
        pix_in_t p;
        p = random_pixel();
        p.frame_start = 1'b1;
        send_pixel(p);
        repeat (20) send_pixel(random_pixel());
    endtask

    // Width 2, so every four pixels form one block; rows alternate without
    // further frame starts.
    task automatic test_extreme_samples();
        pix_in_t p;
        drain();
        write_width(WIDTH_W'(2));
        for (int b = 0; b < 5; b++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                p = '0;
                p.frame_start = (b == 0 && k == 0);
                case (b)
                    0: p = p;
                    1:
                    begin
                        p.chan0 = '1;
                        p.chan1 = '1;
                        p.chan2 = '1;
                    end
                    2:
                    begin
                        p.chan0 = 8'hFF;
                        p.chan1 = 8'h00;
                        p.chan2 = 8'h80;
                    end
                    3:
                    begin
                        p.chan0 = (k == 0) ? 8'd3 : 8'd0;
                        p.chan1 = 8'(k);
                        p.chan2 = (k == 3) ? 8'hFF : 8'hFE;
                    end
                    default: p.chan0 = 8'(1 << k);
                endcase
                send_pixel(p);
            end
        end
    endtask

    task automatic test_odd_width();
        drain();
        write_width(WIDTH_W'(5));
        send_rows(2, 1'b1, 0);
        drain();
        write_width(WIDTH_W'(3));
        send_rows(3, 1'b1, 0);
    endtask

    // Widths below two act as two; widths above MAX_WIDTH act as MAX_WIDTH.
    task automatic test_width_saturation();
        pix_in_t p;
        drain();
        write_width(WIDTH_W'(0));
        send_rows(2, 1'b1, 0);
        drain();
        write_width(WIDTH_W'(1));
        send_rows(2, 1'b1, 0);
        drain();
        write_width('1);
        src_gap_pct = 2;
        sink_stall_pct = 5;
        p = random_pixel();
        p.frame_start = 1'b1;
        send_pixel(p);
        repeat (15) send_pixel(random_pixel());
        src_gap_pct = 15;
        sink_stall_pct = 15;
    endtask

    task automatic test_width_change_midrow();
        pix_in_t p;
        drain();
        write_width(WIDTH_W'(MAX_WIDTH));
        p = random_pixel();
        p.frame_start = 1'b1;
        send_pixel(p);
        repeat (9) send_pixel(random_pixel());
        // The column is already past the new width, so the row ends here.
        drain();
        write_width(WIDTH_W'(6));
        repeat (7) send_pixel(random_pixel());
        // Widen in the middle of an odd row; the tail reads older line entries.
        drain();
        p = random_pixel();
        p.frame_start = 1'b1;
        send_pixel(p);
        repeat (8) send_pixel(random_pixel());
        drain();
        write_width(WIDTH_W'(10));
        repeat (7) send_pixel(random_pixel());
    endtask

    task automatic test_frame_restart();
        pix_in_t p;
        drain();
        write_width(WIDTH_W'(4));
        p = random_pixel();
        p.frame_start = 1'b1;
        send_pixel(p);
        repeat (5) send_pixel(random_pixel());
        p = random_pixel();
        p.frame_start = 1'b1;
        send_pixel(p);
        repeat (7) send_pixel(random_pixel());
    endtask

    // The sink holds off long enough for the command queue to fill up.
    task automatic test_output_backpressure();
        drain();
        write_width(WIDTH_W'(4));
        src_gap_pct = 0;
        hold_request = 400;
        send_rows(16, 1'b1, 0);
        src_gap_pct = 15;
    endtask

    task automatic test_random_frames();
        int unsigned start;
        int unsigned kind;
        int unsigned w;
        int unsigned noise;
        start = pixels_sent;
        while (pixels_sent - start < RANDOM_PIXELS)
        begin
            drain();
            case ($urandom_range(0, 2))
                0: src_gap_pct = 0;
                1: src_gap_pct = 10;
                default: src_gap_pct = 40;
            endcase
            case ($urandom_range(0, 2))
                0: sink_stall_pct = 0;
                1: sink_stall_pct = 10;
                default: sink_stall_pct = 40;
            endcase
            kind = $urandom_range(0, 9);
            if (kind != 0)
            begin
                case ($urandom_range(0, 9))
                    0: w = $urandom_range(0, 1);
                    1: w = $urandom_range(25, 130);
                    2: w = 2 * $urandom_range(1, 12) + 1;
                    default: w = $urandom_range(2, 24);
                endcase
                write_width(WIDTH_W'(w));
            end
            noise = ($urandom_range(0, 3) == 0) ? 20 : 0;
            send_rows($urandom_range(2, 5), kind > 1, noise);
        end
    endtask

    task automatic test_steady_stream();
        drain();
        src_gap_pct = 0;
        sink_stall_pct = 0;
        write_width(WIDTH_W'(8));
        send_rows(16, 1'b1, 0);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_width();
        test_extreme_samples();
        test_odd_width();
        test_width_saturation();
        test_width_change_midrow();
        test_frame_restart();
        test_output_backpressure();
        test_random_frames();
        test_steady_stream();
        drain();
        if (mismatches == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+hdl
hdl/rbd_pkg.sv
hdl/rbd_front.sv
hdl/rbd_queue.sv
hdl/rbd_back.sv
hdl/rgb_box_downscale_2x2.sv
test/rgb_box_downscale_2x2_tb.sv
